/* rtl/assert_macros.svh */
// Assertion macros shared by the qdq RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define QDQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("qdq assertion failed");
`define QDQ_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("qdq assertion failed");
`else
`define QDQ_ASSERT(label, clk, rstn, prop)
`define QDQ_ASSERT_NR(label, clk, prop)
`endif
`endif

/* rtl/qdq_pkg.sv */
// Package for the int8 quantize/dequantize pipeline: widths, codes, types and a leading-zero count.
// No dependencies.
package qdq_pkg;

    localparam int SIG_W = 24;
    localparam int QUO_W = 26;
    localparam int EXP_W = 10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SCALE = 2'd1,
        ST_BAD_INPUT = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic {
        REG_SCALE = 1'b0,
        REG_ZERO  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                    sign;
        logic                    zero;
        logic signed [EXP_W-1:0] dexp;
        status_t                 status;
    } side_t;

    typedef struct packed {
        logic [SIG_W-1:0]        ms;
        logic signed [EXP_W-1:0] es;
    } scale_norm_t;

    typedef struct packed {
        status_t           status;
        logic [31:0]       bits;
        logic signed [7:0] q;
    } result_t;

    function automatic logic [5:0] lzc32(input logic [31:0] x);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

endpackage

/* rtl/int8_quantize_dequantize_top.sv */
// int8 affine quantize/dequantize of binary32 values, one transaction per
// clock cycle while the skid buffer is empty. The 26-stage restoring
// divider forms value/scale one quotient bit per stage; decode comes before
// it, and rounding and the dequantize multiply follow it. An output register
// with a one-entry skid buffer keeps the input side open while a result
// waits. Write scale_bits and zero_point only while the block is empty; a
// written scale reaches the decode and divider through scale_bits_reg and
// then scale_norm_reg. Depends on qdq_pkg, qdq_unpack, qdq_divider,
// qdq_quant, qdq_dequant and assert_macros.svh.
`include "assert_macros.svh"
module int8_quantize_dequantize_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [7:0] quantized, [39:8] dequantized_bits, [41:40] status
);

    logic [31:0]                 scale_bits_reg;
    logic signed [7:0]           zero_point_reg;
    qdq_pkg::scale_norm_t        scale_norm_reg;
    qdq_pkg::scale_norm_t        scale_norm_next;

    logic [7:0]                  s_exp;
    logic [qdq_pkg::SIG_W-1:0]   s_raw;
    logic [7:0]                  s_eb;
    logic [5:0]                  s_lz;
    logic                        bad_scale;

    logic                        en;

    logic                        up_valid;
    qdq_pkg::side_t              up_side;
    logic [qdq_pkg::SIG_W-1:0]   up_mv;

    logic                        dv_valid;
    qdq_pkg::side_t              dv_side;
    logic [qdq_pkg::QUO_W-1:0]   dv_q;
    logic                        dv_sticky;

    logic                        qt_valid;
    logic signed [7:0]           qt_qv;
    logic signed [8:0]           qt_diff;
    qdq_pkg::status_t            qt_status;

    logic                        pipe_valid;
    qdq_pkg::result_t            pipe_result;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    qdq_pkg::result_t            out_reg;
    qdq_pkg::result_t            out_next;
    logic                        skid_valid_reg;
    logic                        skid_valid_next;
    qdq_pkg::result_t            skid_reg;
    qdq_pkg::result_t            skid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_bits_reg <= 32'h3F80_0000;
            zero_point_reg <= 8'sd0;
        end else if (cfg_we) begin
            case (qdq_pkg::reg_idx_t'(cfg_addr))
                qdq_pkg::REG_SCALE: scale_bits_reg <= cfg_wdata;
                qdq_pkg::REG_ZERO:  zero_point_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_exp     = scale_bits_reg[30:23];
        s_raw     = {|s_exp, scale_bits_reg[22:0]};
        s_eb      = (s_exp == 8'd0) ? 8'd1 : s_exp;
        s_lz      = qdq_pkg::lzc32({s_raw, 8'hFF});
        bad_scale = (s_exp == 8'hFF) | scale_bits_reg[31] | (scale_bits_reg == 32'd0);
        scale_norm_next.ms = s_raw << s_lz[4:0];
        scale_norm_next.es = $signed({2'b00, s_eb}) - $signed({4'd0, s_lz});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_norm_reg.ms <= 24'h80_0000;
            scale_norm_reg.es <= '0;
        end else begin
            scale_norm_reg <= scale_norm_next;
        end
    end

    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    qdq_unpack u_unpack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .value_bits (s_tdata),
        .bad_scale  (bad_scale),
        .scale_es   (scale_norm_reg.es),
        .out_valid  (up_valid),
        .out_side   (up_side),
        .out_mv     (up_mv)
    );

    qdq_divider u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (up_valid),
        .in_side    (up_side),
        .in_mv      (up_mv),
        .ms         (scale_norm_reg.ms),
        .out_valid  (dv_valid),
        .out_side   (dv_side),
        .out_q      (dv_q),
        .out_sticky (dv_sticky)
    );

    qdq_quant u_quant (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (dv_valid),
        .in_side    (dv_side),
        .in_q       (dv_q),
        .in_sticky  (dv_sticky),
        .zero_point (zero_point_reg),
        .out_valid  (qt_valid),
        .out_qv     (qt_qv),
        .out_diff   (qt_diff),
        .out_status (qt_status)
    );

    qdq_dequant u_dequant (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (qt_valid),
        .in_qv      (qt_qv),
        .in_diff    (qt_diff),
        .in_status  (qt_status),
        .scale_bits (scale_bits_reg),
        .out_valid  (pipe_valid),
        .out_result (pipe_result)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg) begin
            if (!out_valid_next) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (pipe_valid) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_next       = pipe_result;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = pipe_result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.bits, out_reg.q};

    `QDQ_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `QDQ_ASSERT(a_skid_fill, aclk, aresetn, $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
    `QDQ_ASSERT(a_err_zero, aclk, aresetn, (out_valid_reg && out_reg.status != qdq_pkg::ST_OK) |-> (out_reg.q == 8'sd0 && out_reg.bits == 32'd0))

endmodule

/* rtl/qdq_unpack.sv */
// Input decode and normalization: two stages that split the binary32 value.
// Depends on qdq_pkg.
module qdq_unpack (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [31:0]                        value_bits,
    input  logic                               bad_scale,
    input  logic signed [qdq_pkg::EXP_W-1:0]   scale_es,
    output logic                               out_valid,
    output qdq_pkg::side_t                     out_side,
    output logic [qdq_pkg::SIG_W-1:0]          out_mv
);

    logic                        v1_reg;
    logic                        sign1_reg;
    logic [qdq_pkg::SIG_W-1:0]   raw1_reg;
    logic [7:0]                  eb1_reg;
    logic [4:0]                  lz1_reg;
    qdq_pkg::status_t            status1_reg;

    logic [7:0]                  v_exp;
    logic [qdq_pkg::SIG_W-1:0]   v_raw;
    logic [5:0]                  v_lz;
    qdq_pkg::status_t            v_status;

    logic                        v2_reg;
    qdq_pkg::side_t              side2_reg;
    logic [qdq_pkg::SIG_W-1:0]   mv2_reg;
    qdq_pkg::side_t              side2_next;

    always_comb begin
        v_exp = value_bits[30:23];
        v_raw = {|v_exp, value_bits[22:0]};
        v_lz  = qdq_pkg::lzc32({v_raw, 8'hFF});
        if (bad_scale) begin
            v_status = qdq_pkg::ST_BAD_SCALE;
        end else if (v_exp == 8'hFF) begin
            v_status = qdq_pkg::ST_BAD_INPUT;
        end else begin
            v_status = qdq_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sign1_reg   <= value_bits[31];
            raw1_reg    <= v_raw;
            eb1_reg     <= (v_exp == 8'd0) ? 8'd1 : v_exp;
            lz1_reg     <= v_lz[4:0];
            status1_reg <= v_status;
        end
    end

    always_comb begin
        side2_next.sign   = sign1_reg;
        side2_next.zero   = (raw1_reg == '0);
        side2_next.dexp   = $signed({2'b00, eb1_reg}) - $signed({5'b00000, lz1_reg}) - scale_es;
        side2_next.status = status1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
            mv2_reg   <= raw1_reg << lz1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign out_mv    = mv2_reg;

endmodule

/* rtl/qdq_divider.sv */
// Pipelined restoring divider: one quotient bit per stage over QUO_W stages.
// Depends on qdq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qdq_divider (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  qdq_pkg::side_t                     in_side,
    input  logic [qdq_pkg::SIG_W-1:0]          in_mv,
    input  logic [qdq_pkg::SIG_W-1:0]          ms,
    output logic                               out_valid,
    output qdq_pkg::side_t                     out_side,
    output logic [qdq_pkg::QUO_W-1:0]          out_q,
    output logic                               out_sticky
);

    localparam int N = qdq_pkg::QUO_W;
    localparam int W = qdq_pkg::SIG_W;

    logic                v_reg    [N];
    qdq_pkg::side_t      side_reg [N];
    logic [W-1:0]        rem_reg  [N];
    logic [N-1:0]        q_reg    [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic           vin;
        qdq_pkg::side_t sin;
        logic [W:0]     rem_ext;
        logic [N-1:0]   qin;
        logic [W:0]     trial;
        logic           take;

        if (k == 0) begin : g_first
            assign vin     = in_valid;
            assign sin     = in_side;
            assign rem_ext = {1'b0, in_mv};
            assign qin     = '0;
        end else begin : g_rest
            assign vin     = v_reg[k-1];
            assign sin     = side_reg[k-1];
            assign rem_ext = {rem_reg[k-1], 1'b0};
            assign qin     = q_reg[k-1];
        end

        assign trial = rem_ext - {1'b0, ms};
        assign take  = ~trial[W];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= sin;
                rem_reg[k]  <= take ? trial[W-1:0] : rem_ext[W-1:0];
                q_reg[k]    <= {qin[N-2:0], take};
            end
        end
    end

    assign out_valid  = v_reg[N-1];
    assign out_side   = side_reg[N-1];
    assign out_q      = q_reg[N-1];
    assign out_sticky = |rem_reg[N-1];

    `QDQ_ASSERT(a_quo_norm, aclk, aresetn, (v_reg[N-1] && side_reg[N-1].status == qdq_pkg::ST_OK && !side_reg[N-1].zero) |-> (q_reg[N-1][N-1] || q_reg[N-1][N-2]))

endmodule

/* rtl/qdq_quant.sv */
// Quotient rounding to binary32, then to integer, zero-point add and clamp.
// Three stages. Depends on qdq_pkg.
module qdq_quant (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  qdq_pkg::side_t                in_side,
    input  logic [qdq_pkg::QUO_W-1:0]     in_q,
    input  logic                          in_sticky,
    input  logic signed [7:0]             zero_point,
    output logic                          out_valid,
    output logic signed [7:0]             out_qv,
    output logic signed [8:0]             out_diff,
    output qdq_pkg::status_t              out_status
);

    logic [23:0]                        sig;
    logic                               g;
    logic                               st;
    logic signed [qdq_pkg::EXP_W-1:0]   e;
    logic signed [qdq_pkg::EXP_W-1:0]   e9;

    logic                v1_reg;
    logic [24:0]         sigr1_reg;
    logic [4:0]          sh1_reg;
    logic                big1_reg;
    logic                tiny1_reg;
    logic                sign1_reg;
    qdq_pkg::status_t    status1_reg;

    logic [41:0]         f;
    logic                inc;
    logic [10:0]         mag;
    logic [8:0]          magc;

    logic                v2_reg;
    logic [8:0]          magc2_reg;
    logic                sign2_reg;
    qdq_pkg::status_t    status2_reg;

    logic signed [9:0]   r;
    logic signed [10:0]  sum;
    logic signed [7:0]   qv;

    logic                v3_reg;
    logic signed [7:0]   qv3_reg;
    logic signed [8:0]   diff3_reg;
    qdq_pkg::status_t    status3_reg;

    always_comb begin
        if (in_q[25]) begin
            sig = in_q[25:2];
            g   = in_q[1];
            st  = in_q[0] | in_sticky;
            e   = in_side.dexp;
        end else begin
            sig = in_q[24:1];
            g   = in_q[0];
            st  = in_sticky;
            e   = in_side.dexp - 10'sd1;
        end
        e9 = e + 10'sd9;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sigr1_reg   <= {1'b0, sig} + 25'(g & (st | sig[0]));
            sh1_reg     <= e9[4:0];
            big1_reg    <= (in_side.dexp > 10'sd8);
            tiny1_reg   <= in_side.zero | (in_side.dexp < -10'sd2);
            sign1_reg   <= in_side.sign;
            status1_reg <= in_side.status;
        end
    end

    always_comb begin
        f   = {17'd0, sigr1_reg} << sh1_reg;
        inc = f[31] & (f[32] | (|f[30:0]));
        mag = {1'b0, f[41:32]} + 11'(inc);
        if (tiny1_reg) begin
            magc = 9'd0;
        end else if (big1_reg || mag >= 11'd256) begin
            magc = 9'd256;
        end else begin
            magc = mag[8:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            magc2_reg   <= magc;
            sign2_reg   <= sign1_reg;
            status2_reg <= status1_reg;
        end
    end

    always_comb begin
        r   = sign2_reg ? -$signed({1'b0, magc2_reg}) : $signed({1'b0, magc2_reg});
        sum = {r[9], r} + {{3{zero_point[7]}}, zero_point};
        if (sum > 11'sd127) begin
            qv = 8'sd127;
        end else if (sum < -11'sd128) begin
            qv = -8'sd128;
        end else begin
            qv = sum[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qv3_reg     <= qv;
            diff3_reg   <= {qv[7], qv} - {zero_point[7], zero_point};
            status3_reg <= status2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_qv     = qv3_reg;
    assign out_diff   = diff3_reg;
    assign out_status = status3_reg;

endmodule

/* rtl/qdq_dequant.sv */
// Dequantize: integer times binary32 scale, normalize, round, pack.
// Four stages. Depends on qdq_pkg.
module qdq_dequant (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [7:0]    in_qv,
    input  logic signed [8:0]    in_diff,
    input  qdq_pkg::status_t     in_status,
    input  logic [31:0]          scale_bits,
    output logic                 out_valid,
    output qdq_pkg::result_t     out_result
);

    logic [7:0]          s_exp;
    logic [23:0]         ss;
    logic [7:0]          eb;
    logic [8:0]          dneg_ext;
    logic [7:0]          dmag;

    logic                v1_reg;
    logic [31:0]         p1_reg;
    logic                dneg1_reg;
    logic signed [7:0]   qv1_reg;
    qdq_pkg::status_t    status1_reg;

    logic [5:0]          lz;

    logic                v2_reg;
    logic [31:0]         p2_reg;
    logic [3:0]          sh2_reg;
    logic                pzero2_reg;
    logic                dneg2_reg;
    logic signed [7:0]   qv2_reg;
    qdq_pkg::status_t    status2_reg;

    logic [32:0]         ext;
    logic [32:0]         sft;
    logic [32:0]         low_mask;
    logic [23:0]         mant;
    logic                g;
    logic                st;

    logic                v3_reg;
    logic [24:0]         mant3_reg;
    logic [8:0]          ebx3_reg;
    logic                pzero3_reg;
    logic                dneg3_reg;
    logic signed [7:0]   qv3_reg;
    qdq_pkg::status_t    status3_reg;

    logic [32:0]         sum;
    logic                ovf;
    qdq_pkg::result_t    res_next;

    logic                v4_reg;
    qdq_pkg::result_t    res4_reg;

    always_comb begin
        s_exp    = scale_bits[30:23];
        ss       = {|s_exp, scale_bits[22:0]};
        eb       = (s_exp == 8'd0) ? 8'd1 : s_exp;
        dneg_ext = -in_diff;
        dmag     = in_diff[8] ? dneg_ext[7:0] : in_diff[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg      <= {24'd0, dmag} * {8'd0, ss};
            dneg1_reg   <= in_diff[8];
            qv1_reg     <= in_qv;
            status1_reg <= in_status;
        end
    end

    assign lz = qdq_pkg::lzc32(p1_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg      <= p1_reg;
            sh2_reg     <= (lz <= 6'd8) ? 4'(6'd8 - lz) : 4'd0;
            pzero2_reg  <= (p1_reg == 32'd0);
            dneg2_reg   <= dneg1_reg;
            qv2_reg     <= qv1_reg;
            status2_reg <= status1_reg;
        end
    end

    always_comb begin
        ext      = {p2_reg, 1'b0};
        sft      = ext >> sh2_reg;
        mant     = sft[24:1];
        g        = sft[0];
        low_mask = (33'd1 << sh2_reg) - 33'd1;
        st       = |(ext & low_mask);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mant3_reg   <= {1'b0, mant} + 25'(g & (st | mant[0]));
            ebx3_reg    <= {1'b0, eb} + {5'd0, sh2_reg} - 9'd1;
            pzero3_reg  <= pzero2_reg;
            dneg3_reg   <= dneg2_reg;
            qv3_reg     <= qv2_reg;
            status3_reg <= status2_reg;
        end
    end

    always_comb begin
        sum = {1'b0, ebx3_reg, 23'd0} + {8'd0, mant3_reg};
        ovf = (sum[32:23] >= 10'd255);
        res_next.q    = qv3_reg;
        res_next.bits = pzero3_reg ? 32'd0 : {dneg3_reg, sum[30:0]};
        if (status3_reg != qdq_pkg::ST_OK) begin
            res_next.status = status3_reg;
        end else if (ovf) begin
            res_next.status = qdq_pkg::ST_OVERFLOW;
        end else begin
            res_next.status = qdq_pkg::ST_OK;
        end
        if (res_next.status != qdq_pkg::ST_OK) begin
            res_next.q    = 8'sd0;
            res_next.bits = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res4_reg <= res_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_result = res4_reg;

endmodule
